// ===== sv/command_frame_receiver_with_rollback_defines.svh =====
// ============================================================================
// Assertion macros for the command frame receiver
// Shared implication forms, clocked on i_clk, off during reset.
// ============================================================================
`ifndef COMMAND_FRAME_RECEIVER_WITH_ROLLBACK_DEFINES_SVH
`define COMMAND_FRAME_RECEIVER_WITH_ROLLBACK_DEFINES_SVH

// same-cycle implication
`define CFRR_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define CFRR_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/cfrr_pkg.sv =====
// ============================================================================
// cfrr_pkg
// Constants, codes and types of the command frame receiver.
// ============================================================================
package cfrr_pkg;

    localparam int RING_DEPTH = 32;
    localparam int RING_AW    = $clog2(RING_DEPTH);
    localparam int MAX_FRAME  = 256;

    // command codes
    localparam logic [1:0] CMD_RX     = 2'd0;
    localparam logic [1:0] CMD_ENQ    = 2'd1;
    localparam logic [1:0] CMD_TX     = 2'd2;
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    // register indexes
    localparam logic [1:0] CFG_ENQ_LIMIT = 2'd0;
    localparam logic [1:0] CFG_DM_LIMIT  = 2'd1;
    localparam logic [1:0] CFG_SEQ_START = 2'd2;

    // line bytes
    localparam logic [7:0] BYTE_ESC  = 8'd27;
    localparam logic [7:0] BYTE_SYNC = 8'd3;
    localparam logic [7:0] BYTE_XON  = 8'd17;
    localparam logic [7:0] BYTE_XOFF = 8'd19;

    localparam logic [12:0] CODE_ROLLBACK = 13'd4;

    // result status codes
    localparam logic [3:0] ST_FLOW     = 4'd0;
    localparam logic [3:0] ST_DISCARD  = 4'd1;
    localparam logic [3:0] ST_FBYTE    = 4'd2;
    localparam logic [3:0] ST_LEN_ERR  = 4'd3;
    localparam logic [3:0] ST_FORWARD  = 4'd4;
    localparam logic [3:0] ST_RB_FOUND = 4'd5;
    localparam logic [3:0] ST_RB_MISS  = 4'd6;
    localparam logic [3:0] ST_RB_IGN   = 4'd7;
    localparam logic [3:0] ST_ENQ      = 4'd8;
    localparam logic [3:0] ST_REFUSED  = 4'd9;
    localparam logic [3:0] ST_SENT     = 4'd10;
    localparam logic [3:0] ST_IDLE     = 4'd11;

    // link sync states
    localparam logic [1:0] SYNC_DOWN = 2'd0;
    localparam logic [1:0] SYNC_REQ  = 2'd1;
    localparam logic [1:0] SYNC_OK   = 2'd2;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_EXEC = 4'b0010,
        S_TXD  = 4'b0100,
        S_SCAN = 4'b1000
    } t_state;

endpackage

// ===== sv/command_frame_receiver_with_rollback.sv =====
// Received bytes and enqueues run in S_EXEC, which registers the result; a transmit
// goes on to S_TXD for the ring RAM read. Rollback search reads one ring slot per cycle
// through the RAM read port, from slot 0 up to the sent count or the first hit.
// A new beat is accepted only in idle and after the last result has been taken.
// Reset (synchronous, active low) clears control and config; ring RAM not cleared.
// ============================================================================
// command_frame_receiver_with_rollback
// Serial command deframer with a retransmit ring of sequence numbers.
// ============================================================================
`include "command_frame_receiver_with_rollback_defines.svh"

module command_frame_receiver_with_rollback (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // input channel
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [1:0]         i_cmd,
    input  logic [7:0]         i_rx_byte,
    input  logic               i_link_up,
    // output channel
    output logic               o_valid,
    input  logic               i_ready,
    output logic [3:0]         o_status,
    output logic [8:0]         o_frame_pos,
    output logic signed [12:0] o_command_code,
    output logic [7:0]         o_seq_number,
    output logic [4:0]         o_ring_slot,
    output logic               o_inhibit,
    output logic [1:0]         o_sync_state,
    output logic [4:0]         o_ring_used,
    // config
    input  logic               i_cfg_wen,
    input  logic [1:0]         i_cfg_idx,
    input  logic [7:0]         i_cfg_data
);
    import cfrr_pkg::*;

    t_state               r_state;
    logic [1:0]           r_cmd;
    logic [7:0]           r_byte;
    logic                 r_link;
    logic [4:0]           r_enq_lim;
    logic [2:0]           r_dm_lim;
    logic [RING_AW-1:0]   r_wp;
    logic [RING_AW-1:0]   r_rp;
    logic [7:0]           r_next_seq;
    logic [RING_AW:0]     r_sent;
    logic [1:0]           r_sync;
    logic [2:0]           r_inh_cnt;
    logic                 r_prev_link;
    logic [8:0]           r_fidx;
    logic [8:0]           r_flen;
    logic [7:0]           r_prev_byte;
    logic [7:0]           r_h3;
    logic [7:0]           r_h4;
    logic [7:0]           r_tail [4];
    logic [7:0]           r_last_rb;
    logic [2:0]           r_dm_cnt;
    logic [7:0]           r_want;
    logic                 r_dm_exp;
    logic [RING_AW:0]     r_j;
    logic                 r_ovalid;
    logic [3:0]           r_o_status;
    logic [8:0]           r_o_pos;
    logic [12:0]          r_o_code;
    logic [7:0]           r_o_seq;
    logic [4:0]           r_o_slot;
    logic                 r_o_inh;

    logic                 ram_wen;
    logic [RING_AW-1:0]   ram_raddr;
    logic [7:0]           ram_rdata;

    // deframer terms for the byte in r_byte
    logic                 c_flow;
    logic                 c_start;
    logic                 c_active;
    logic [8:0]           c_p;
    logic signed [17:0]   c_nc;
    logic                 c_bad;
    logic [8:0]           c_len;
    logic                 c_done;
    logic [7:0]           c_t [4];
    logic [12:0]          c_code;
    logic [7:0]           c_want;
    logic [2:0]           c_dm_new;
    logic [4:0]           c_used;
    logic                 c_refuse;
    logic [1:0]           c_sync_tx;
    logic                 c_hit;

    always_comb begin
        c_flow   = (r_byte == BYTE_XON) || (r_byte == BYTE_XOFF);
        c_start  = (r_fidx == 9'd0) && (r_byte == BYTE_SYNC) && (r_prev_byte == BYTE_ESC);
        c_active = (r_fidx != 9'd0) || c_start;
        c_p      = c_start ? 9'd2 : r_fidx;
        c_nc     = $signed({2'b0, r_byte, 8'b0}) + $signed({6'b0, r_h3, 4'b0})
                 + $signed({10'b0, r_h4}) - 18'sd8736;
        c_bad    = (c_nc < 18'sd15) || (c_nc > 18'(MAX_FRAME));
        if (c_p == 9'd6) begin
            c_len = c_nc[8:0];
        end else if (c_start) begin
            c_len = 9'd7;
        end else begin
            c_len = r_flen;
        end
        c_done = (({1'b0, c_p} + 10'd1) > {1'b0, c_len}) && (c_len > 9'd14);
        for (int k = 0; k < 4; k++) begin
            if (c_p == 9'(27 + k)) begin
                c_t[k] = r_byte;
            end else if (c_start) begin
                c_t[k] = 8'd0;
            end else begin
                c_t[k] = r_tail[k];
            end
        end
        c_code   = {1'b0, c_t[0], 4'b0} + {5'b0, c_t[1]} - 13'd544;
        c_want   = {c_t[2][3:0], 4'b0} + c_t[3] + 8'd224;
        if (c_want == r_last_rb) begin
            c_dm_new = (r_dm_cnt < 3'd7) ? r_dm_cnt + 3'd1 : r_dm_cnt;
        end else begin
            c_dm_new = 3'd0;
        end
        c_used    = 5'(r_wp - r_rp);
        c_refuse  = !r_link || (RING_AW'(r_wp + 1'b1) == r_rp) || (c_used > r_enq_lim);
        c_sync_tx = (r_link != r_prev_link) ? {1'b0, r_link} : r_sync;
        c_hit     = (ram_rdata == r_want);
    end

    // RAM read address: transmit slot, first or next scanned slot
    always_comb begin
        case (r_state)
            S_EXEC:  ram_raddr = (r_cmd == CMD_TX) ? r_rp : '0;
            S_SCAN:  ram_raddr = RING_AW'(r_j + 1'b1);
            default: ram_raddr = r_rp;
        endcase
        ram_wen = (r_state == S_EXEC) && (r_cmd == CMD_ENQ) && !c_refuse;
    end

    cfrr_ram #(
        .DEPTH (RING_DEPTH),
        .WIDTH (8)
    ) u_ring (
        .i_clk   (i_clk),
        .i_wen   (ram_wen),
        .i_waddr (r_wp),
        .i_wdata (r_next_seq),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign o_ready = (r_state == S_IDLE) && !r_ovalid;

    // main sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_enq_lim   <= 5'd8;
            r_dm_lim    <= 3'd5;
            r_wp        <= '0;
            r_rp        <= '0;
            r_next_seq  <= 8'd250;
            r_sent      <= '0;
            r_sync      <= SYNC_DOWN;
            r_inh_cnt   <= 3'd2;
            r_prev_link <= 1'b0;
            r_fidx      <= '0;
            r_flen      <= '0;
            r_prev_byte <= '0;
            r_h3        <= '0;
            r_h4        <= '0;
            for (int k = 0; k < 4; k++) begin
                r_tail[k] <= '0;
            end
            r_last_rb   <= '0;
            r_dm_cnt    <= '0;
            r_ovalid    <= 1'b0;
        end else begin
            if (r_ovalid && i_ready) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_valid && o_ready) begin
                        r_cmd   <= i_cmd;
                        r_byte  <= i_rx_byte;
                        r_link  <= i_link_up;
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    r_state    <= S_IDLE;
                    r_ovalid   <= 1'b1;
                    r_o_status <= ST_IDLE;
                    r_o_pos    <= '0;
                    r_o_code   <= '0;
                    r_o_seq    <= '0;
                    r_o_slot   <= '0;
                    r_o_inh    <= 1'b0;
                    case (r_cmd)
                        CMD_RX: begin
                            if (c_flow) begin
                                r_o_status <= ST_FLOW;
                            end else begin
                                r_prev_byte <= r_byte;
                                if (r_fidx == 9'd0 && !c_start && r_byte != BYTE_ESC) begin
                                    r_sync <= SYNC_REQ;
                                end
                                if (!c_active) begin
                                    r_o_status <= ST_DISCARD;
                                end else begin
                                    // header and tail capture
                                    if (c_start) begin
                                        r_h3 <= '0;
                                        r_h4 <= '0;
                                    end
                                    if (c_p == 9'd3) r_h3 <= r_byte;
                                    if (c_p == 9'd4) r_h4 <= r_byte;
                                    for (int k = 0; k < 4; k++) begin
                                        r_tail[k] <= c_t[k];
                                    end
                                    r_o_pos <= c_p;
                                    if (c_p == 9'd6 && c_bad) begin
                                        r_fidx     <= '0;
                                        r_sync     <= SYNC_REQ;
                                        r_o_status <= ST_LEN_ERR;
                                    end else begin
                                        r_flen <= c_len;
                                        if (!c_done) begin
                                            r_fidx     <= c_p + 9'd1;
                                            r_o_status <= ST_FBYTE;
                                        end else begin
                                            r_fidx   <= '0;
                                            r_o_code <= c_code;
                                            if (c_code != CODE_ROLLBACK) begin
                                                r_o_status <= ST_FORWARD;
                                            end else begin
                                                // rollback request
                                                r_sync <= SYNC_OK;
                                                if (r_inh_cnt != 3'd0) begin
                                                    r_o_status <= ST_RB_IGN;
                                                end else begin
                                                    r_dm_cnt  <= c_dm_new;
                                                    r_last_rb <= c_want;
                                                    r_want    <= c_want;
                                                    r_dm_exp  <= c_dm_new > r_dm_lim;
                                                    r_o_seq   <= c_want;
                                                    if (r_sent == '0) begin
                                                        r_inh_cnt  <= 3'd4;
                                                        r_o_status <= ST_RB_MISS;
                                                        r_o_slot   <= 5'(r_rp);
                                                    end else begin
                                                        r_inh_cnt <= 3'd1;
                                                        r_j       <= '0;
                                                        r_ovalid  <= 1'b0;
                                                        r_state   <= S_SCAN;
                                                    end
                                                end
                                            end
                                        end
                                    end
                                end
                            end
                        end
                        CMD_ENQ: begin
                            if (c_refuse) begin
                                r_o_status <= ST_REFUSED;
                            end else begin
                                r_o_status <= ST_ENQ;
                                r_o_slot   <= 5'(r_wp);
                                r_o_seq    <= r_next_seq;
                                r_wp       <= RING_AW'(r_wp + 1'b1);
                                r_next_seq <= r_next_seq + 8'd1;
                                if (r_sent < (RING_AW + 1)'(RING_DEPTH)) begin
                                    r_sent <= r_sent + 1'b1;
                                end
                            end
                        end
                        CMD_TX: begin
                            r_sync      <= c_sync_tx;
                            r_prev_link <= r_link;
                            if (r_wp != r_rp && r_link && c_sync_tx == SYNC_OK) begin
                                r_ovalid <= 1'b0;
                                r_state  <= S_TXD;
                            end
                        end
                        default: begin
                            r_o_status <= ST_IDLE;
                        end
                    endcase
                end
                S_TXD: begin
                    r_state    <= S_IDLE;
                    r_ovalid   <= 1'b1;
                    r_o_status <= ST_SENT;
                    r_o_seq    <= ram_rdata;
                    r_o_slot   <= 5'(r_rp);
                    r_o_inh    <= r_inh_cnt != 3'd0;
                    if (r_inh_cnt != 3'd0) begin
                        r_inh_cnt <= r_inh_cnt - 3'd1;
                    end
                    r_rp <= RING_AW'(r_rp + 1'b1);
                end
                S_SCAN: begin
                    // ram_rdata holds slot r_j
                    if (c_hit || (r_j + 1'b1 == r_sent)) begin
                        r_state    <= S_IDLE;
                        r_ovalid   <= 1'b1;
                        r_o_status <= c_hit ? ST_RB_FOUND : ST_RB_MISS;
                        if (!c_hit || r_dm_exp) begin
                            r_inh_cnt <= 3'd4;
                        end
                        if (c_hit) begin
                            r_rp     <= r_j[RING_AW-1:0];
                            r_o_slot <= 5'(r_j[RING_AW-1:0]);
                        end else if (r_sent == (RING_AW + 1)'(RING_DEPTH)) begin
                            r_rp     <= RING_AW'(r_wp + 2'd2);
                            r_o_slot <= 5'(RING_AW'(r_wp + 2'd2));
                        end else begin
                            r_o_slot <= 5'(r_rp);
                        end
                    end else begin
                        r_j <= r_j + 1'b1;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
            // config writes, to be made only while idle; the block itself does not enforce this
            if (i_cfg_wen) begin
                case (i_cfg_idx)
                    CFG_ENQ_LIMIT: r_enq_lim  <= i_cfg_data[4:0];
                    CFG_DM_LIMIT:  r_dm_lim   <= i_cfg_data[2:0];
                    CFG_SEQ_START: r_next_seq <= i_cfg_data;
                    default:       ;
                endcase
            end
        end
    end

    assign o_valid        = r_ovalid;
    assign o_status       = r_o_status;
    assign o_frame_pos    = r_o_pos;
    assign o_command_code = $signed(r_o_code);
    assign o_seq_number   = r_o_seq;
    assign o_ring_slot    = r_o_slot;
    assign o_inhibit      = r_o_inh;
    assign o_sync_state   = r_sync;
    assign o_ring_used    = 5'(r_wp - r_rp);

    // checks
    `CFRR_ASSERT_NOW(a_ready_no_result, o_ready, !o_valid, "ready while result pending")
    `CFRR_ASSERT_NXT(a_accept_exec, i_valid && o_ready, r_state == S_EXEC, "accept not executed")
    `CFRR_ASSERT_NOW(a_scan_bound, r_state == S_SCAN, r_j < r_sent, "scan past sent slots")
    `CFRR_ASSERT_NOW(a_busy_no_valid, r_state != S_IDLE, !o_valid || r_state == S_EXEC,
                     "result during ring access")

endmodule

// ===== sv/cfrr_ram.sv =====
// ============================================================================
// cfrr_ram
// Simple dual-port RAM, one write and one registered read port.
// ============================================================================
module cfrr_ram #(
    parameter int DEPTH = 32,
    parameter int WIDTH = 8
) (
    input  logic                     i_clk,
    input  logic                     i_wen,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_wen) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== test/command_frame_receiver_with_rollback_tb.sv =====
// ============================================================================
// command_frame_receiver_with_rollback_tb
// Drives command beats (serial bytes, enqueue and transmit requests) with
// random gaps. A behavioral copy of the deframer and retransmit ring works
// out the expected result of every beat. The monitor compares each result
// field by field, in order.
// ============================================================================
module command_frame_receiver_with_rollback_tb;
    import cfrr_pkg::*;

    typedef struct {
        logic [1:0] cmd;
        logic [7:0] rx_byte;
        logic       link;
    } beat_t;

    typedef struct {
        logic [3:0]  status;
        logic [8:0]  pos;
        logic [12:0] code;
        logic [7:0]  seq;
        logic [4:0]  slot;
        logic        inh;
        logic [1:0]  sync;
        logic [4:0]  used;
    } result_t;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic o_ready;
    logic [1:0] i_cmd = '0;
    logic [7:0] i_rx_byte = '0;
    logic i_link_up = 1'b0;
    logic o_valid;
    logic i_ready = 1'b0;
    logic [3:0] o_status;
    logic [8:0] o_frame_pos;
    logic signed [12:0] o_command_code;
    logic [7:0] o_seq_number;
    logic [4:0] o_ring_slot;
    logic o_inhibit;
    logic [1:0] o_sync_state;
    logic [4:0] o_ring_used;
    logic i_cfg_wen = 1'b0;
    logic [1:0] i_cfg_idx = '0;
    logic [7:0] i_cfg_data = '0;

    command_frame_receiver_with_rollback DUT (.*);

    always #10 i_clk = ~i_clk;

    beat_t   beat_q[$];
    result_t result_q[$];
    int      fail_cnt = 0;
    bit      gaps_on = 1'b1;
    bit      send_pause = 1'b0;
    bit      paused_once = 1'b0;
    int      hold_req = 0;

    // ---------------- behavioral copy of the block ----------------
    logic [4:0] cfg_enq_limit = 5'd8;
    logic [2:0] cfg_dm_limit  = 3'd5;

    logic [7:0] ring [RING_DEPTH];
    logic [4:0] wr_ptr = '0, rd_ptr = '0;
    logic [7:0] next_seq = 8'd250;
    int         sent_cnt = 0;
    logic [1:0] link_sync = SYNC_DOWN;
    int         inhibit_cnt = 2;
    logic       prev_link = 1'b0;
    int         frame_idx = 0;
    int         frame_len = 0;
    logic [7:0] prev_byte = '0;
    logic [7:0] hdr [7];
    logic [7:0] tail [4];
    logic [7:0] last_rb_seq = '0;
    int         deadman_cnt = 0;

    initial begin
        foreach (ring[k]) ring[k] = '0;
        foreach (hdr[k]) hdr[k] = '0;
        foreach (tail[k]) tail[k] = '0;
    end

    // rollback: search the ring for the requested sequence, rewind read side
    function automatic logic [3:0] rewind_ring(output logic [7:0] seq_o,
                                              output logic [4:0] slot_o);
        int  want;
        int  ncheck;
        bit  found;
        want = (int'(tail[2]) * 16 + int'(tail[3]) + 224) & 255;
        ncheck = (sent_cnt < RING_DEPTH) ? sent_cnt : RING_DEPTH;
        found = 1'b0;
        seq_o = '0;
        slot_o = '0;
        link_sync = SYNC_OK;
        if (inhibit_cnt > 0) return ST_RB_IGN;
        if (want[7:0] == last_rb_seq) begin
            if (deadman_cnt < 7) deadman_cnt++;
        end else begin
            deadman_cnt = 0;
        end
        last_rb_seq = want[7:0];
        inhibit_cnt = 1;
        for (int j = 0; j < ncheck && !found; j++) begin
            if (ring[j] == want[7:0]) begin
                rd_ptr = j[4:0];
                found = 1'b1;
            end
        end
        if ((!found && ncheck != RING_DEPTH) || deadman_cnt > int'(cfg_dm_limit))
            inhibit_cnt = 4;
        if (!found && ncheck == RING_DEPTH) begin
            rd_ptr = wr_ptr + 5'd2;
            inhibit_cnt = 4;
        end
        seq_o = want[7:0];
        slot_o = rd_ptr;
        return found ? ST_RB_FOUND : ST_RB_MISS;
    endfunction

    function automatic result_t predict_beat(beat_t bt);
        result_t r;
        int p, nc, code;
        bit len_err;
        logic [7:0] sq;
        logic [4:0] sl;
        r = '{status: ST_IDLE, default: '0};
        case (bt.cmd)
            CMD_RX: begin
                if (bt.rx_byte == BYTE_XON || bt.rx_byte == BYTE_XOFF) begin
                    r.status = ST_FLOW;
                end else begin
                    r.status = ST_DISCARD;
                    // hunt for ESC followed by the sync byte
                    if (frame_idx == 0) begin
                        if (bt.rx_byte == BYTE_SYNC && prev_byte == BYTE_ESC) begin
                            frame_idx = 2;
                            foreach (hdr[k]) hdr[k] = '0;
                            foreach (tail[k]) tail[k] = '0;
                            hdr[1] = BYTE_ESC;
                            frame_len = 7;
                        end else if (bt.rx_byte != BYTE_ESC) begin
                            link_sync = SYNC_REQ;
                        end
                    end
                    if (frame_idx != 0) begin
                        p = frame_idx;
                        len_err = 1'b0;
                        if (p < 7) hdr[p] = bt.rx_byte;
                        else if (p >= 27 && p <= 30) tail[p - 27] = bt.rx_byte;
                        r.pos = p[8:0];
                        r.status = ST_FBYTE;
                        if (p == 6) begin
                            nc = (int'(hdr[3]) - 32) * 16 + (int'(hdr[4]) - 32)
                               + (int'(hdr[6]) - 32) * 256;
                            if (nc < 15 || nc > MAX_FRAME) begin
                                frame_idx = 0;
                                link_sync = SYNC_REQ;
                                r.status = ST_LEN_ERR;
                                len_err = 1'b1;
                            end else begin
                                frame_len = nc;
                            end
                        end
                        if (!len_err) begin
                            frame_idx = p + 1;
                            if (frame_idx > frame_len && frame_len > 14) begin
                                code = (int'(tail[0]) - 32) * 16 + (int'(tail[1]) - 32);
                                r.code = code[12:0];
                                frame_idx = 0;
                                if (code[12:0] == CODE_ROLLBACK) begin
                                    r.status = rewind_ring(sq, sl);
                                    r.seq = sq;
                                    r.slot = sl;
                                end else begin
                                    r.status = ST_FORWARD;
                                end
                            end
                        end
                    end
                    prev_byte = bt.rx_byte;
                end
            end
            CMD_ENQ: begin
                if (!bt.link || wr_ptr + 5'd1 == rd_ptr || (wr_ptr - rd_ptr) > cfg_enq_limit) begin
                    r.status = ST_REFUSED;
                end else begin
                    r.slot = wr_ptr;
                    r.seq = next_seq;
                    ring[wr_ptr] = next_seq;
                    wr_ptr++;
                    next_seq++;
                    if (sent_cnt < RING_DEPTH) sent_cnt++;
                    r.status = ST_ENQ;
                end
            end
            CMD_TX: begin
                if (bt.link != prev_link) begin
                    link_sync = bt.link ? SYNC_REQ : SYNC_DOWN;
                    prev_link = bt.link;
                end
                if (wr_ptr != rd_ptr && bt.link && link_sync == SYNC_OK) begin
                    r.slot = rd_ptr;
                    r.seq = ring[rd_ptr];
                    if (inhibit_cnt > 0) begin
                        r.inh = 1'b1;
                        inhibit_cnt--;
                    end
                    rd_ptr++;
                    r.status = ST_SENT;
                end
            end
            default: ;
        endcase
        r.sync = link_sync;
        r.used = wr_ptr - rd_ptr;
        return r;
    endfunction

    // ---------------- stimulus helpers ----------------
    task automatic push_beat(logic [1:0] cmd, logic [7:0] b, logic link);
        beat_t bt;
        bt = '{cmd: cmd, rx_byte: b, link: link};
        beat_q.push_back(bt);
        result_q.push_back(predict_beat(bt));
    endtask

    task automatic push_byte(logic [7:0] b);
        push_beat(CMD_RX, b, 1'($urandom_range(0, 1)));
    endtask

    // well-formed frame; rollback frames carry code 4 and a requested sequence
    task automatic push_frame(int len, bit rb, logic [7:0] want);
        logic [7:0] b;
        push_byte(BYTE_ESC);
        push_byte(BYTE_SYNC);
        for (int p = 3; p <= len; p++) begin
            case (p)
                3: b = 8'(32 + len / 16);
                4: b = 8'(32 + len % 16);
                6: b = 8'd32;
                27: b = rb ? 8'd32 : 8'($urandom_range(0, 255));
                28: b = rb ? 8'd36 : 8'($urandom_range(0, 255));
                29: b = rb ? 8'(34 + want[7:4]) : 8'($urandom_range(0, 255));
                30: b = rb ? {4'd0, want[3:0]} : 8'($urandom_range(0, 255));
                default: b = 8'($urandom_range(0, 255));
            endcase
            // flow bytes inside a frame are dropped without moving position
            if ($urandom_range(0, 49) == 0) push_byte($urandom_range(0, 1) ? BYTE_XON : BYTE_XOFF);
            push_byte(b);
        end
    endtask

    task automatic push_bad_frame();
        push_byte(BYTE_ESC);
        push_byte(BYTE_SYNC);
        case ($urandom_range(0, 2))
            0: begin  // length 14, one below the floor
                push_byte(8'd32); push_byte(8'd46); push_byte(8'd0); push_byte(8'd32);
            end
            1: begin  // length 257, one above the ceiling
                push_byte(8'd48); push_byte(8'd33); push_byte(8'd0); push_byte(8'd32);
            end
            default: for (int k = 0; k < 4; k++) push_byte(8'($urandom_range(0, 255)));
        endcase
    endtask

    task automatic wait_drained();
        while (beat_q.size() != 0 || i_valid || result_q.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_register(logic [1:0] idx, logic [7:0] val);
        wait_drained();
        repeat (40) @(posedge i_clk);
        i_cfg_wen <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_wen <= 1'b0;
        case (idx)
            CFG_ENQ_LIMIT: cfg_enq_limit = val[4:0];
            CFG_DM_LIMIT:  cfg_dm_limit = val[2:0];
            CFG_SEQ_START: next_seq = val;
            default: ;
        endcase
    endtask

    function automatic int pick_gap();
        int r;
        if (!gaps_on) return 0;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // ---------------- sender ----------------
    int    send_gap = 0;
    beat_t cur;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!i_valid || o_ready) begin
            if (send_gap > 0) begin
                send_gap <= send_gap - 1;
                i_valid <= 1'b0;
            end else if (beat_q.size() != 0 && !send_pause) begin
                cur = beat_q.pop_front();
                i_cmd <= cur.cmd;
                i_rx_byte <= cur.rx_byte;
                i_link_up <= cur.link;
                i_valid <= 1'b1;
                send_gap <= pick_gap();
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // ---------------- receiver and checker ----------------
    int hold_left = 0;
    int hold_seen = 0;
    int recv_gap = 0;

    task automatic report(string what, logic [12:0] got, logic [12:0] want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        fail_cnt++;
    endtask

    always @(posedge i_clk) begin
        result_t e;
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            if (o_valid && i_ready) begin
                if (result_q.size() == 0) begin
                    report("unexpected beat, status", 13'(o_status), '0);
                end else begin
                    e = result_q.pop_front();
                    if (o_status != e.status) report("status", 13'(o_status), 13'(e.status));
                    if (o_frame_pos != e.pos) report("frame_pos", 13'(o_frame_pos), 13'(e.pos));
                    if (o_command_code != e.code) report("command_code", o_command_code, e.code);
                    if (o_seq_number != e.seq) report("seq_number", 13'(o_seq_number), 13'(e.seq));
                    if (o_ring_slot != e.slot) report("ring_slot", 13'(o_ring_slot), 13'(e.slot));
                    if (o_inhibit != e.inh) report("inhibit", 13'(o_inhibit), 13'(e.inh));
                    if (o_sync_state != e.sync) report("sync_state", 13'(o_sync_state), 13'(e.sync));
                    if (o_ring_used != e.used) report("ring_used", 13'(o_ring_used), 13'(e.used));
                end
            end
            // long hold-off on request, else random stalls
            if (hold_left > 0) begin
                hold_left <= hold_left - 1;
                i_ready <= 1'b0;
            end else if (hold_seen != hold_req) begin
                hold_seen <= hold_req;
                hold_left <= 400;
                i_ready <= 1'b0;
            end else if (recv_gap > 0) begin
                recv_gap <= recv_gap - 1;
                i_ready <= 1'b0;
            end else begin
                i_ready <= 1'b1;
                recv_gap <= pick_gap();
            end
        end
    end

    // ---------------- watchdog ----------------
    int quiet = 0;
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready)) quiet <= 0;
        else quiet <= quiet + 1;
        if (quiet >= 5000) begin
            $display("command_frame_receiver_with_rollback_tb NOT OK");
            $finish;
        end
    end

    // ---------------- test sequence ----------------
    logic [7:0] want;
    int r, len;
    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: flow bytes, unused command, refusals, length error
        push_beat(CMD_UNUSED, 8'hFF, 1'b1);
        push_beat(CMD_TX, 8'd0, 1'b0);
        push_byte(BYTE_XON);
        push_byte(BYTE_XOFF);
        push_byte(8'd0);
        push_byte(8'hFF);
        push_byte(BYTE_ESC);
        push_beat(CMD_ENQ, 8'd0, 1'b0);
        push_beat(CMD_ENQ, 8'd0, 1'b1);
        push_beat(CMD_ENQ, 8'hAA, 1'b1);
        push_beat(CMD_TX, 8'd0, 1'b1);
        push_byte(BYTE_ESC);
        push_byte(BYTE_SYNC);
        push_byte(8'hFF);
        push_byte(8'd0);
        push_byte(8'h55);
        push_byte(8'hFF);
        push_frame(15, 1'b0, 8'd0);

        for (int ph = 0; ph < 5; ph++) begin
            case (ph)
                1: begin
                    write_register(CFG_ENQ_LIMIT, 8'd0);
                    write_register(CFG_DM_LIMIT, 8'd0);
                    write_register(CFG_SEQ_START, 8'd0);
                end
                2: begin
                    write_register(CFG_ENQ_LIMIT, 8'd31);
                    write_register(CFG_DM_LIMIT, 8'd7);
                    write_register(CFG_SEQ_START, 8'd255);
                end
                3: begin
                    write_register(CFG_ENQ_LIMIT, 8'($urandom_range(0, 31)));
                    write_register(CFG_DM_LIMIT, 8'($urandom_range(0, 7)));
                    write_register(CFG_SEQ_START, 8'($urandom_range(0, 255)));
                end
                4: write_register(CFG_ENQ_LIMIT, 8'd30);
                default: ;
            endcase
            gaps_on = (ph != 2);
            if (ph == 1) hold_req++;
            while (beat_q.size() < 400) begin
                r = $urandom_range(0, 99);
                if (r < 25) begin
                    push_beat(CMD_ENQ, 8'($urandom_range(0, 255)), $urandom_range(0, 9) != 0);
                end else if (r < 50) begin
                    push_beat(CMD_TX, 8'($urandom_range(0, 255)), $urandom_range(0, 14) != 0);
                end else if (r < 65) begin
                    // request a sequence held in the ring, a repeat, or a stranger
                    case ($urandom_range(0, 3))
                        0: want = last_rb_seq;
                        1: want = 8'($urandom_range(0, 255));
                        default: want = (sent_cnt > 0) ? ring[$urandom_range(0, sent_cnt - 1)]
                                                       : 8'($urandom_range(0, 255));
                    endcase
                    push_frame($urandom_range(30, 40), 1'b1, want);
                end else if (r < 75) begin
                    len = ($urandom_range(0, 49) == 0) ? MAX_FRAME : $urandom_range(15, 40);
                    push_frame(len, 1'b0, 8'd0);
                end else if (r < 82) begin
                    push_bad_frame();
                end else if (r < 98) begin
                    push_byte(8'($urandom_range(0, 255)));
                end else begin
                    push_beat(CMD_UNUSED, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
                end
                // sender waits for every result once in the middle of a phase
                if (ph == 3 && !paused_once && beat_q.size() >= 200) begin
                    paused_once = 1'b1;
                    while (beat_q.size() > 100) @(posedge i_clk);
                    @(negedge i_clk);
                    send_pause = 1'b1;
                    while (i_valid || result_q.size() != beat_q.size()) @(posedge i_clk);
                    @(negedge i_clk);
                    send_pause = 1'b0;
                end
            end
            wait_drained();
        end

        wait_drained();
        repeat (50) @(posedge i_clk);
        if (fail_cnt == 0) begin
            $display("command_frame_receiver_with_rollback_tb OK");
        end else begin
            $display("command_frame_receiver_with_rollback_tb NOT OK");
        end
        $finish;
    end

endmodule
